// File: hdl/nfl_pkg.sv
package nfl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 18;
  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 18;

  localparam logic signed [W-1:0] S_MAX = 18'sh1FFFF;
  localparam logic signed [W-1:0] S_MIN = -18'sh20000;
  localparam logic signed [W-1:0] S_ONE = 18'sh10000;

  typedef struct packed {
    logic signed [W-1:0] nx;
    logic signed [W-1:0] ny;
    logic signed [W-1:0] nz;
    logic signed [W-1:0] lx;
    logic signed [W-1:0] ly;
    logic signed [W-1:0] lz;
  } vec_t;

  function automatic logic signed [W-1:0] sat18(input logic signed [39:0] v);
    logic signed [W-1:0] r;
    if (v > 40'sd131071) begin
      r = S_MAX;
    end else if (v < -40'sd131072) begin
      r = S_MIN;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // Round half up and drop the fraction bits, then saturate.
  function automatic logic signed [W-1:0] rnd_sat(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = (v + 40'sd32768) >>> FRAC_BITS;
    return sat18(t);
  endfunction

endpackage

// File: hdl/nfl_tangent.sv
module nfl_tangent (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_i,
  input  nfl_pkg::vec_t           vec_i,
  output logic                    v_o,
  output nfl_pkg::vec_t           vec_o,
  output logic signed [17:0]      sx_o,
  output logic signed [17:0]      sy_o
);
  import nfl_pkg::*;

  // Square of nz and the clamped difference from one.
  logic        v1_r, v2_r;
  vec_t        vec1_r, vec2_r;
  logic [34:0] sq1_r;
  logic [32:0] d2_r;
  logic signed [35:0] sq_full;

  assign sq_full = vec_i.nz * vec_i.nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1_r <= vec_i;
      sq1_r  <= sq_full[34:0];
      vec2_r <= vec1_r;
      if (sq1_r > 35'h100000000) begin
        d2_r <= '0;
      end else begin
        d2_r <= 33'h100000000 - sq1_r[32:0];
      end
    end
  end

  // Square root, one result bit per stage.
  logic        sv_r  [0:SQRT_STEPS-1];
  vec_t        svec_r[0:SQRT_STEPS-1];
  logic [16:0] rt_r  [0:SQRT_STEPS-1];
  logic [17:0] rm_r  [0:SQRT_STEPS-1];
  logic [33:0] sd_r  [0:SQRT_STEPS-1];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic        v_in;
      vec_t        vec_in;
      logic [16:0] rt_in;
      logic [17:0] rm_in;
      logic [33:0] d_in;
      logic [19:0] remsh;
      logic [18:0] trial;
      logic        take;
      logic [19:0] diff;

      if (k == 0) begin : g_first
        assign v_in   = v2_r;
        assign vec_in = vec2_r;
        assign rt_in  = '0;
        assign rm_in  = '0;
        assign d_in   = {1'b0, d2_r};
      end else begin : g_next
        assign v_in   = sv_r[k-1];
        assign vec_in = svec_r[k-1];
        assign rt_in  = rt_r[k-1];
        assign rm_in  = rm_r[k-1];
        assign d_in   = sd_r[k-1];
      end

      assign remsh = {rm_in, d_in[2*(SQRT_STEPS-1-k)+1 -: 2]};
      assign trial = {rt_in, 2'b01};
      assign take  = remsh >= {1'b0, trial};
      assign diff  = remsh - {1'b0, trial};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[k] <= 1'b0;
        end else if (en) begin
          sv_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          svec_r[k] <= vec_in;
          sd_r[k]   <= d_in;
          rt_r[k]   <= {rt_in[15:0], take};
          rm_r[k]   <= take ? diff[17:0] : remsh[17:0];
        end
      end
    end
  endgenerate

  // Division set-up: sign and magnitude of the dividends, overflow test.
  logic        dv0_r;
  vec_t        dvec0_r;
  logic [16:0] z0_r;
  logic        dgn0_r;
  logic [33:0] mx0_r, my0_r;
  logic        sgx0_r, sgy0_r, ovx0_r, ovy0_r;
  logic [17:0] ax, ay;
  logic [16:0] zs;
  vec_t        vs;

  assign zs = rt_r[SQRT_STEPS-1];
  assign vs = svec_r[SQRT_STEPS-1];
  assign ax = vs.ny[17] ? 18'(-vs.ny) : 18'(vs.ny);
  assign ay = vs.nx[17] ? 18'(-vs.nx) : 18'(vs.nx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_r <= 1'b0;
    end else if (en) begin
      dv0_r <= sv_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvec0_r <= vs;
      z0_r    <= zs;
      dgn0_r  <= (zs == '0);
      mx0_r   <= {ax, 16'b0};
      my0_r   <= {ay, 16'b0};
      sgx0_r  <= vs.ny[17];
      sgy0_r  <= (vs.nx > 18'sd0);
      ovx0_r  <= ({1'b0, ax[17:2]} >= zs);
      ovy0_r  <= ({1'b0, ay[17:2]} >= zs);
    end
  end

  // Restoring division, one quotient bit per stage for both lanes.
  logic        qv_r  [0:DIV_STEPS-1];
  vec_t        qvec_r[0:DIV_STEPS-1];
  logic [16:0] qz_r  [0:DIV_STEPS-1];
  logic        qdg_r [0:DIV_STEPS-1];
  logic [33:0] qmx_r [0:DIV_STEPS-1];
  logic [33:0] qmy_r [0:DIV_STEPS-1];
  logic        qsx_r [0:DIV_STEPS-1];
  logic        qsy_r [0:DIV_STEPS-1];
  logic        qox_r [0:DIV_STEPS-1];
  logic        qoy_r [0:DIV_STEPS-1];
  logic [16:0] rx_r  [0:DIV_STEPS-1];
  logic [16:0] ry_r  [0:DIV_STEPS-1];
  logic [17:0] qx_r  [0:DIV_STEPS-1];
  logic [17:0] qy_r  [0:DIV_STEPS-1];

  genvar j;
  generate
    for (j = 0; j < DIV_STEPS; j++) begin : g_div
      logic        v_in, dg_in, sx_in, sy_in, ox_in, oy_in;
      vec_t        vec_in;
      logic [16:0] z_in, rx_in, ry_in;
      logic [33:0] mx_in, my_in;
      logic [17:0] qx_in, qy_in;
      logic [17:0] rx2, ry2, dx, dy;
      logic        tx, ty;

      if (j == 0) begin : g_first
        assign v_in   = dv0_r;
        assign vec_in = dvec0_r;
        assign z_in   = z0_r;
        assign dg_in  = dgn0_r;
        assign mx_in  = mx0_r;
        assign my_in  = my0_r;
        assign sx_in  = sgx0_r;
        assign sy_in  = sgy0_r;
        assign ox_in  = ovx0_r;
        assign oy_in  = ovy0_r;
        assign rx_in  = {1'b0, mx0_r[33:18]};
        assign ry_in  = {1'b0, my0_r[33:18]};
        assign qx_in  = '0;
        assign qy_in  = '0;
      end else begin : g_next
        assign v_in   = qv_r[j-1];
        assign vec_in = qvec_r[j-1];
        assign z_in   = qz_r[j-1];
        assign dg_in  = qdg_r[j-1];
        assign mx_in  = qmx_r[j-1];
        assign my_in  = qmy_r[j-1];
        assign sx_in  = qsx_r[j-1];
        assign sy_in  = qsy_r[j-1];
        assign ox_in  = qox_r[j-1];
        assign oy_in  = qoy_r[j-1];
        assign rx_in  = rx_r[j-1];
        assign ry_in  = ry_r[j-1];
        assign qx_in  = qx_r[j-1];
        assign qy_in  = qy_r[j-1];
      end

      assign rx2 = {rx_in, mx_in[DIV_STEPS-1-j]};
      assign ry2 = {ry_in, my_in[DIV_STEPS-1-j]};
      assign tx  = rx2 >= {1'b0, z_in};
      assign ty  = ry2 >= {1'b0, z_in};
      assign dx  = rx2 - {1'b0, z_in};
      assign dy  = ry2 - {1'b0, z_in};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          qv_r[j] <= 1'b0;
        end else if (en) begin
          qv_r[j] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          qvec_r[j] <= vec_in;
          qz_r[j]   <= z_in;
          qdg_r[j]  <= dg_in;
          qmx_r[j]  <= mx_in;
          qmy_r[j]  <= my_in;
          qsx_r[j]  <= sx_in;
          qsy_r[j]  <= sy_in;
          qox_r[j]  <= ox_in;
          qoy_r[j]  <= oy_in;
          rx_r[j]   <= tx ? dx[16:0] : rx2[16:0];
          ry_r[j]   <= ty ? dy[16:0] : ry2[16:0];
          qx_r[j]   <= {qx_in[16:0], tx};
          qy_r[j]   <= {qy_in[16:0], ty};
        end
      end
    end
  endgenerate

  // Apply sign, saturation and the degenerate tangent.
  localparam int L = DIV_STEPS - 1;
  logic               fv_r;
  vec_t               fvec_r;
  logic signed [17:0] fsx_r, fsy_r;
  logic signed [39:0] sxv, syv;

  assign sxv = qsx_r[L] ? -$signed({22'b0, qx_r[L]}) : $signed({22'b0, qx_r[L]});
  assign syv = qsy_r[L] ? -$signed({22'b0, qy_r[L]}) : $signed({22'b0, qy_r[L]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= qv_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fvec_r <= qvec_r[L];
      if (qdg_r[L]) begin
        fsx_r <= S_ONE;
        fsy_r <= '0;
      end else begin
        fsx_r <= qox_r[L] ? (qsx_r[L] ? S_MIN : S_MAX) : sat18(sxv);
        fsy_r <= qoy_r[L] ? (qsy_r[L] ? S_MIN : S_MAX) : sat18(syv);
      end
    end
  end

  assign v_o   = fv_r;
  assign vec_o = fvec_r;
  assign sx_o  = fsx_r;
  assign sy_o  = fsy_r;

endmodule

// File: hdl/normal_frame_local_to_world_core.sv
// Local-to-world direction transform about a unit normal, Q2.16 fixed point.
// Input channel: in_valid/in_ready with the normal (in_normal_*) and the
// local direction (in_local_*). Result channel: out_valid/out_ready with the
// world direction (out_world_*), every component saturated to 18 bits.
// Each input beat gives exactly one result beat, in order.
// From input beat to result valid, two stages form 1 - nz^2, seventeen
// compute the square root one bit a stage, one sets up the division,
// eighteen produce the tangent quotients one bit a stage, one applies
// saturation, and four form the bitangent and the weighted sum.
// Throughput is one beat per cycle while the receiver takes results.
// The whole pipeline advances together; when the output register holds a
// result that is not taken, every stage holds and in_ready is low, so no
// beat is lost or repeated. Bubbles are not squeezed out during a stall.
// Synchronous reset empties every stage; payload registers are not reset.
module normal_frame_local_to_world_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] in_normal_x,
  input  logic signed [17:0] in_normal_y,
  input  logic signed [17:0] in_normal_z,
  input  logic signed [17:0] in_local_x,
  input  logic signed [17:0] in_local_y,
  input  logic signed [17:0] in_local_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_world_x,
  output logic signed [17:0] out_world_y,
  output logic signed [17:0] out_world_z
);
  import nfl_pkg::*;

  logic               en;
  vec_t               vin;
  logic               tv;
  vec_t               tvec;
  logic signed [17:0] tsx, tsy;
  logic               out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign vin.nx = in_normal_x;
  assign vin.ny = in_normal_y;
  assign vin.nz = in_normal_z;
  assign vin.lx = in_local_x;
  assign vin.ly = in_local_y;
  assign vin.lz = in_local_z;

  nfl_tangent u_tangent (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (in_valid && en),
    .vec_i (vin),
    .v_o   (tv),
    .vec_o (tvec),
    .sx_o  (tsx),
    .sy_o  (tsy)
  );

  // Bitangent products.
  logic               av_r;
  vec_t               avec_r;
  logic signed [17:0] asx_r, asy_r;
  logic signed [35:0] ptx_r, pty_r, pz1_r, pz2_r;

  // Bitangent rounding.
  logic               bv_r;
  vec_t               bvec_r;
  logic signed [17:0] bsx_r, bsy_r, btx_r, bty_r, btz_r;
  logic signed [39:0] tz_nxt;

  // Weighted products.
  logic               cv_r;
  logic signed [35:0] c0_r, c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;

  logic signed [17:0] wx_r, wy_r, wz_r;

  assign tz_nxt = 40'(pz1_r) - 40'(pz2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r        <= 1'b0;
      bv_r        <= 1'b0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      av_r        <= tv;
      bv_r        <= av_r;
      cv_r        <= bv_r;
      out_valid_r <= cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      avec_r <= tvec;
      asx_r  <= tsx;
      asy_r  <= tsy;
      ptx_r  <= tvec.nz * tsy;
      pty_r  <= tvec.nz * tsx;
      pz1_r  <= tvec.nx * tsy;
      pz2_r  <= tvec.ny * tsx;

      bvec_r <= avec_r;
      bsx_r  <= asx_r;
      bsy_r  <= asy_r;
      btx_r  <= rnd_sat(-40'(ptx_r));
      bty_r  <= rnd_sat(40'(pty_r));
      btz_r  <= rnd_sat(tz_nxt);

      c0_r <= bvec_r.lx * bsx_r;
      c1_r <= bvec_r.ly * btx_r;
      c2_r <= bvec_r.lz * bvec_r.nx;
      c3_r <= bvec_r.lx * bsy_r;
      c4_r <= bvec_r.ly * bty_r;
      c5_r <= bvec_r.lz * bvec_r.ny;
      c6_r <= bvec_r.ly * btz_r;
      c7_r <= bvec_r.lz * bvec_r.nz;

      wx_r <= rnd_sat(40'(c0_r) + 40'(c1_r) + 40'(c2_r));
      wy_r <= rnd_sat(40'(c3_r) + 40'(c4_r) + 40'(c5_r));
      wz_r <= rnd_sat(40'(c6_r) + 40'(c7_r));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_world_x = wx_r;
  assign out_world_y = wy_r;
  assign out_world_z = wz_r;

endmodule

// File: hdl/nfl_checker.sv
module nfl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] out_world_x,
  input logic signed [17:0] out_world_y,
  input logic signed [17:0] out_world_z
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_world_x) &&
      $stable(out_world_y) && $stable(out_world_z))
    else $error("stalled result beat changed");

  // With no result waiting, the block must take input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled receiver stalls the input side too.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind normal_frame_local_to_world_core nfl_checker u_nfl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_world_x (out_world_x),
  .out_world_y (out_world_y),
  .out_world_z (out_world_z)
);

// File: dv/normal_frame_local_to_world_core_tb.sv
`timescale 1ns / 100ps

module normal_frame_local_to_world_core_tb;
  import nfl_pkg::*;

  localparam int N_RANDOM  = 550;
  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [17:0] wx;
    logic signed [17:0] wy;
    logic signed [17:0] wz;
  } world_t;

  function automatic longint sat_w(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Round half up, then drop the fraction bits (arithmetic shift is a floor).
  function automatic longint round_frac(longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > x) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic world_t to_world(vec_t v);
    longint nx, ny, nz, lx, ly, lz, d, z, sx, sy, tx, ty, tz;
    world_t r;
    nx = v.nx; ny = v.ny; nz = v.nz; lx = v.lx; ly = v.ly; lz = v.lz;
    d = (64'sd1 <<< (2 * FRAC_BITS)) - nz * nz;
    if (d < 0) d = 0;
    z = int_sqrt(d);
    if (z < 1) begin
      sx = 64'sd1 <<< FRAC_BITS;
      sy = 0;
    end else begin
      sx = (ny * (64'sd1 <<< FRAC_BITS)) / z;
      sy = (-nx * (64'sd1 <<< FRAC_BITS)) / z;
    end
    sx = sat_w(sx);
    sy = sat_w(sy);
    tx = sat_w(round_frac(-nz * sy));
    ty = sat_w(round_frac(nz * sx));
    tz = sat_w(round_frac(nx * sy - ny * sx));
    r.wx = 18'(sat_w(round_frac(lx * sx + ly * tx + lz * nx)));
    r.wy = 18'(sat_w(round_frac(lx * sy + ly * ty + lz * ny)));
    r.wz = 18'(sat_w(round_frac(ly * tz + lz * nz)));
    return r;
  endfunction

  class world_scoreboard;
    world_t pending[$];
    int errors;

    function void note_input(vec_t v);
      pending.push_back(to_world(v));
    endfunction

    function void check_result(world_t got);
      world_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing pending: %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.wx !== exp_w.wx) begin
        $display("%0t: world_x expected %0d actual %0d", $time, exp_w.wx, got.wx);
        errors++;
      end
      if (got.wy !== exp_w.wy) begin
        $display("%0t: world_y expected %0d actual %0d", $time, exp_w.wy, got.wy);
        errors++;
      end
      if (got.wz !== exp_w.wz) begin
        $display("%0t: world_z expected %0d actual %0d", $time, exp_w.wz, got.wz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [17:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic signed [17:0] in_local_x = '0, in_local_y = '0, in_local_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [17:0] out_world_x, out_world_y, out_world_z;

  world_scoreboard sb = new();
  int cycle_count = 0;
  bit sink_on = 1'b0;

  normal_frame_local_to_world_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("normal_frame_local_to_world_core_tb: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Result side: check each accepted beat, stall at random.
  int sink_hold = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_world_x, out_world_y, out_world_z});
    if (!sink_on) begin
      out_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_hold <= gap_len();
    end
  end

  // Valid stays high from one beat to the next when there is no gap.
  task automatic send_beat(vec_t v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_normal_x <= v.nx; in_normal_y <= v.ny; in_normal_z <= v.nz;
    in_local_x <= v.lx; in_local_y <= v.ly; in_local_z <= v.lz;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
  endtask

  function automatic logic signed [17:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return S_MAX;
      1: return S_MIN;
      2: return 18'($urandom_range(0, 131071));
      default: return 18'($urandom);
    endcase
  endfunction

  // A roughly unit normal: two random components and the third from the norm.
  function automatic vec_t unit_normal_item();
    vec_t v;
    longint a, b, c2;
    a = $signed(18'($urandom_range(0, 131071) - 65536));
    b = $signed(18'($urandom_range(0, 131071) - 65536));
    if (a * a + b * b > (64'sd1 <<< 32)) b = 0;
    c2 = (64'sd1 <<< 32) - a * a - b * b;
    v.nx = 18'(a); v.ny = 18'(b);
    v.nz = 18'(int_sqrt(c2));
    if ($urandom_range(0, 1)) v.nz = -v.nz;
    v.lx = 18'($urandom_range(0, 131071) - 65536);
    v.ly = 18'($urandom_range(0, 131071) - 65536);
    v.lz = 18'($urandom_range(0, 131071) - 65536);
    return v;
  endfunction

  initial begin
    vec_t v;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    sink_on = 1'b1;

    // Directed: poles, degenerate tangent, nz beyond one, field extremes.
    send_beat('{18'sd0, 18'sd0, S_ONE, S_ONE, S_ONE, S_ONE});
    send_beat('{18'sd0, 18'sd0, -S_ONE, S_ONE, -S_ONE, S_ONE});
    send_beat('{18'sd0, 18'sd0, S_MAX, S_MAX, S_MAX, S_MAX});
    send_beat('{18'sd0, 18'sd0, S_MIN, S_MIN, S_MIN, S_MIN});
    send_beat('{S_ONE, 18'sd0, 18'sd0, S_ONE, S_ONE, S_ONE});
    send_beat('{18'sd0, S_ONE, 18'sd0, S_MIN, S_MAX, S_MIN});
    send_beat('{S_MAX, S_MAX, 18'sd0, S_MAX, S_MAX, S_MAX});
    send_beat('{S_MIN, S_MIN, 18'sd0, S_MIN, S_MIN, S_MIN});
    send_beat('{S_MAX, S_MIN, 18'sd1, S_MAX, S_MIN, S_MAX});
    send_beat('{S_MIN, S_MAX, 18'sd65535, S_MIN, S_MAX, S_MIN});
    send_beat('{18'sd1, -18'sd1, -18'sd65535, S_MAX, S_MAX, S_MIN});
    send_beat('{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0});
    send_beat('{18'sd46341, 18'sd0, 18'sd46341, S_ONE, 18'sd0, 18'sd0});

    // Hold the sender until the pipeline has fully drained.
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        v = unit_normal_item();
      end else begin
        v = '{rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
              rnd_field()};
      end
      send_beat(v);
      if (i == N_RANDOM / 2) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("normal_frame_local_to_world_core_tb: clean");
    end else begin
      $display("normal_frame_local_to_world_core_tb: errors");
    end
    $finish;
  end

endmodule
